>>> rtl/core/depth_to_color_map_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the depth colormap core RTL
// ----------------------------------------------------------------------------
`ifndef DEPTH_TO_COLOR_MAP_CORE_MACROS_SVH
`define DEPTH_TO_COLOR_MAP_CORE_MACROS_SVH

// same-cycle implication, masked while reset is high
`define DTCM_ASSERT_IMP(name, clk, rst, pre, con) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (con)) \
      else $error("assertion failed");

// next-cycle implication, masked while reset is high
`define DTCM_ASSERT_NEXT(name, clk, rst, pre, con) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (con)) \
      else $error("assertion failed");

`endif

>>> rtl/core/dtcm_pkg.sv
// ----------------------------------------------------------------------------
// dtcm_pkg
// Widths, stage map, register and segment codes of the depth colormap core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtcm_pkg;

   localparam int DEPTH_BITS = 16;   // used depth bits, 8..32
   localparam int FRAC_BITS  = 8;    // level fraction bits, 0..16

   localparam int FIELD_BITS = 16;
   localparam int CHAN_BITS  = 8;
   localparam int DW = (DEPTH_BITS < FIELD_BITS) ? DEPTH_BITS : FIELD_BITS;
   localparam int QW = 8 + FRAC_BITS;              // level width
   localparam int NW = DW + QW;                    // numerator width

   // divider: DIV_STEPS quotient bits resolved per stage
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
   localparam int QP = DIV_STAGES * DIV_STEPS;     // padded quotient width
   localparam int WW = DW + QP;                    // {remainder, numerator/quotient}

   // stage map
   localparam int ST_FRONT = 0;
   localparam int ST_NUM   = 1;
   localparam int ST_DIV0  = 2;
   localparam int ST_SEG   = ST_DIV0 + DIV_STAGES;
   localparam int ST_OUT   = ST_SEG + 1;
   localparam int NST      = ST_OUT + 1;

   localparam logic [QW-1:0] LVL_43  = QW'(43)  << FRAC_BITS;
   localparam logic [QW-1:0] LVL_85  = QW'(85)  << FRAC_BITS;
   localparam logic [QW-1:0] LVL_128 = QW'(128) << FRAC_BITS;
   localparam logic [QW-1:0] LVL_169 = QW'(169) << FRAC_BITS;
   localparam logic [QW-1:0] LVL_212 = QW'(212) << FRAC_BITS;
   localparam logic [QW-1:0] LVL_254 = QW'(254) << FRAC_BITS;
   localparam logic [QW-1:0] LVL_255 = QW'(255) << FRAC_BITS;

   localparam logic [CHAN_BITS-1:0] CHAN_MAX = '1;
   localparam int RAMP_SLOPE = 6;

   typedef enum logic [0:0] {
      CSR_WINDOW_LOW  = 1'b0,
      CSR_WINDOW_HIGH = 1'b1
   } csr_index_type;

   // colormap segments, named by the ramp they run
   typedef enum logic [2:0] {
      SEG_MAGENTA = 3'd0,
      SEG_BLUE    = 3'd1,
      SEG_CYAN    = 3'd2,
      SEG_GREEN   = 3'd3,
      SEG_YELLOW  = 3'd4,
      SEG_RED     = 3'd5,
      SEG_SAT     = 3'd6
   } seg_type;

endpackage

>>> rtl/core/depth_to_color_map_core.sv
// Depth colormap core: takes one 16-bit depth word per clock and returns one
// RGB word per clock after NST register stages, while the result side takes
// words. Depths outside [window_low, window_high] give black; inside the
// window the level 255*(d-low)/(high-low) is found by a pipelined restoring
// divider that resolves four quotient bits per stage, followed by a
// segment-select stage and a ramp/saturate stage. A stall on the result side
// only holds stages that are full, so bubbles still close up. The window
// registers are written through the csr_ port; the user must write them only
// while the core holds no words, as the core itself does not enforce this.
// ----------------------------------------------------------------------------
// depth_to_color_map_core
// Piecewise-linear rainbow colormap for depth samples, fully pipelined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "depth_to_color_map_core_macros.svh"

module depth_to_color_map_core
   import dtcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_write_enable,
   input  logic [0:0]            csr_index,
   input  logic [FIELD_BITS-1:0] csr_write_data,
   // depth words in
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FIELD_BITS-1:0] req_depth_sample,
   // color words out
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAN_BITS-1:0]  rsp_red,
   output logic [CHAN_BITS-1:0]  rsp_green,
   output logic [CHAN_BITS-1:0]  rsp_blue
);

   // ---------------- configuration ----------------
   logic [FIELD_BITS-1:0] window_low_ff;
   logic [FIELD_BITS-1:0] window_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff  <= '0;
         window_high_ff <= FIELD_BITS'(2000);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_LOW:  window_low_ff  <= csr_write_data;
            CSR_WINDOW_HIGH: window_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;
   logic [NST-1:0] en;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign v_in      = {v_ff[NST-2:0], req_valid};
   assign req_ready = en[ST_FRONT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   // ---------------- front: window test, offset, span ----------------
   logic [DW-1:0] depth_m;
   logic [DW-1:0] low_m;
   logic [DW-1:0] high_m;
   logic          black0_in;
   logic [DW-1:0] diff0_in;
   logic [DW-1:0] span0_in;
   logic          black0_ff;
   logic [DW-1:0] diff0_ff;
   logic [DW-1:0] span0_ff;

   assign depth_m   = req_depth_sample[DW-1:0];
   assign low_m     = window_low_ff[DW-1:0];
   assign high_m    = window_high_ff[DW-1:0];
   assign black0_in = (depth_m < low_m) || (depth_m > high_m);
   assign diff0_in  = black0_in ? '0 : depth_m - low_m;
   // zero-width window: numerator is zero, a divisor of one keeps t at zero
   assign span0_in  = (high_m == low_m) ? DW'(1) : high_m - low_m;

   always_ff @(posedge clock) begin
      if (en[ST_FRONT]) begin
         black0_ff <= black0_in;
         diff0_ff  <= diff0_in;
         span0_ff  <= span0_in;
      end
   end

   // ---------------- numerator: (255 * diff) << FRAC_BITS ----------------
   logic [NW-1:0] num1_in;
   logic [NW-1:0] num1_ff;
   logic [DW-1:0] span1_ff;
   logic          black1_ff;

   assign num1_in = ((NW'(diff0_ff) << 8) - NW'(diff0_ff)) << FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en[ST_NUM]) begin
         num1_ff   <= num1_in;
         span1_ff  <= span0_ff;
         black1_ff <= black0_ff;
      end
   end

   // ---------------- restoring divider ----------------
   logic [WW-1:0] src_w     [DIV_STAGES];
   logic [DW-1:0] src_d     [DIV_STAGES];
   logic          src_b     [DIV_STAGES];
   logic [WW-1:0] w_in      [DIV_STAGES];
   logic [WW-1:0] w_ff      [DIV_STAGES];
   logic [DW-1:0] dspan_ff  [DIV_STAGES];
   logic          dblack_ff [DIV_STAGES];

   always_comb begin
      src_w[0] = WW'(num1_ff);
      src_d[0] = span1_ff;
      src_b[0] = black1_ff;
      for (int s = 1; s < DIV_STAGES; s++) begin
         src_w[s] = w_ff[s-1];
         src_d[s] = dspan_ff[s-1];
         src_b[s] = dblack_ff[s-1];
      end
   end

   // word = {remainder, unused numerator bits, quotient bits so far}
   always_comb begin
      logic [WW-1:0] work;
      logic [DW:0]   part;
      logic [DW:0]   sub;
      for (int s = 0; s < DIV_STAGES; s++) begin
         work = src_w[s];
         for (int i = 0; i < DIV_STEPS; i++) begin
            part = work[WW-1 -: DW+1];
            sub  = part - {1'b0, src_d[s]};
            if (part >= {1'b0, src_d[s]}) begin
               work = {sub[DW-1:0], work[QP-2:0], 1'b1};
            end else begin
               work = {part[DW-1:0], work[QP-2:0], 1'b0};
            end
         end
         w_in[s] = work;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (en[ST_DIV0+s]) begin
            w_ff[s]      <= w_in[s];
            dspan_ff[s]  <= src_d[s];
            dblack_ff[s] <= src_b[s];
         end
      end
   end

   // ---------------- segment select ----------------
   logic [QW-1:0] level;
   seg_type       seg_in;
   logic [QW-1:0] off_in;
   seg_type       seg_ff;
   logic [QW-1:0] off_ff;
   logic          black_seg_ff;

   assign level = w_ff[DIV_STAGES-1][QW-1:0];

   always_comb begin
      priority if (level < LVL_43) begin
         seg_in = SEG_MAGENTA;
         off_in = level;
      end else if (level < LVL_85) begin
         seg_in = SEG_BLUE;
         off_in = level - LVL_43;
      end else if (level < LVL_128) begin
         seg_in = SEG_CYAN;
         off_in = level - LVL_85;
      end else if (level < LVL_169) begin
         seg_in = SEG_GREEN;
         off_in = level - LVL_128;
      end else if (level < LVL_212) begin
         seg_in = SEG_YELLOW;
         off_in = level - LVL_169;
      end else if (level < LVL_254) begin
         seg_in = SEG_RED;
         off_in = level - LVL_212;
      end else begin
         seg_in = SEG_SAT;
         off_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SEG]) begin
         seg_ff       <= seg_in;
         off_ff       <= off_in;
         black_seg_ff <= dblack_ff[DIV_STAGES-1];
      end
   end

   // ---------------- ramps and channel output ----------------
   logic [QW+2:0]          prod;
   logic [QW+2-FRAC_BITS:0] rise;
   logic [QW-1:0]          fall_fix;
   logic [CHAN_BITS-1:0]   up_val;
   logic [CHAN_BITS-1:0]   down_val;
   logic [CHAN_BITS-1:0]   red_in;
   logic [CHAN_BITS-1:0]   green_in;
   logic [CHAN_BITS-1:0]   blue_in;
   logic [CHAN_BITS-1:0]   red_ff;
   logic [CHAN_BITS-1:0]   green_ff;
   logic [CHAN_BITS-1:0]   blue_ff;

   assign prod     = (QW+3)'(off_ff) * (QW+3)'(RAMP_SLOPE);
   assign rise     = prod[QW+2:FRAC_BITS];
   assign up_val   = (rise > (QW+3-FRAC_BITS)'(CHAN_MAX)) ? CHAN_MAX : rise[CHAN_BITS-1:0];
   assign fall_fix = LVL_255 - prod[QW-1:0];
   // falling ramp clamps at zero once the drop reaches full scale
   assign down_val = (prod >= (QW+3)'(LVL_255)) ? '0 : fall_fix[QW-1:FRAC_BITS];

   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      unique case (seg_ff)
         SEG_MAGENTA: begin
            red_in  = up_val;
            blue_in = up_val;
         end
         SEG_BLUE: begin
            red_in  = down_val;
            blue_in = CHAN_MAX;
         end
         SEG_CYAN: begin
            green_in = up_val;
            blue_in  = CHAN_MAX;
         end
         SEG_GREEN: begin
            green_in = CHAN_MAX;
            blue_in  = down_val;
         end
         SEG_YELLOW: begin
            red_in   = up_val;
            green_in = CHAN_MAX;
         end
         SEG_RED: begin
            red_in   = CHAN_MAX;
            green_in = down_val;
         end
         SEG_SAT: begin
            red_in = CHAN_MAX;
         end
         default: ;
      endcase
      if (black_seg_ff) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = v_ff[ST_OUT];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // ---------------- assertions ----------------
   `DTCM_ASSERT_NEXT(a_accept_fills_front, clock, reset, req_valid && req_ready, v_ff[ST_FRONT])
   `DTCM_ASSERT_IMP(a_divisor_nonzero, clock, reset, v_ff[ST_FRONT], span0_ff != '0)
   `DTCM_ASSERT_IMP(a_level_in_range, clock, reset, v_ff[ST_SEG-1], w_ff[DIV_STAGES-1][QP-1:0] <= QP'(LVL_255))
   `DTCM_ASSERT_IMP(a_remainder_below_divisor, clock, reset, v_ff[ST_SEG-1], w_ff[DIV_STAGES-1][WW-1:QP] < dspan_ff[DIV_STAGES-1])

endmodule
